>>> rtl/mmfn_pkg.sv
// Shared types and constants for the min-max feature normalizer.
// No dependencies; imported by every module of the block except mmfn_ram.
package mmfn_pkg;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int COL_W     = 6;
  localparam int COL_LIMIT = 1 << COL_W;
  localparam int FRAC_BITS = 16;
  localparam int CNT_W     = $clog2(FRAC_BITS + 1);

  localparam logic [FRAC_BITS-1:0] FRAC_MAX = '1;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  // Opcodes
  localparam logic [OP_W-1:0] OP_OBSERVE   = 2'd0;
  localparam logic [OP_W-1:0] OP_NORMALIZE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OBS,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/mmfn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the per-column extremes store.
module mmfn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/mmfn_div.sv
// Restoring divider, one quotient bit per cycle, FRAC_BITS steps.
// Requires num < den; depends on mmfn_pkg.
module mmfn_div import mmfn_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] num,
  input  logic [SAMPLE_BITS-1:0] den,
  output logic [FRAC_BITS-1:0]   quot,
  output div_stat_t              stat
);

  logic [SAMPLE_BITS-1:0] rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] den_r;
  logic [FRAC_BITS-1:0]   quot_r, quot_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [SAMPLE_BITS:0]   shifted;
  logic [SAMPLE_BITS:0]   diff;
  logic                   ge;

  // one restoring step; remainder stays below den
  assign shifted = {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      quot_nxt = '0;
      cnt_nxt  = CNT_W'(FRAC_BITS);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
      quot_nxt = {quot_r[FRAC_BITS-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign quot      = quot_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

>>> rtl/min_max_feature_normalizer_core.sv
// Top level of the min-max feature normalizer.
// Depends on mmfn_pkg, mmfn_ram and mmfn_div.

// Per-column min-max scaler. An observe item folds a signed sample into its
// column's running minimum and maximum (the first sample sets both). A
// normalize item returns (sample - min) / (max - min) as an unsigned Q0.16
// fraction, truncated; a zero range counts as one, results below zero give
// 0 and results of one or more give 65535. Normalizing a column that was
// never observed, or one at or beyond MAX_COLUMNS, returns 0 with
// out_column_unseen set. A clear item forgets every column at once. Only
// normalize items produce a result. Items are taken one at a time: in_stall
// is high from acceptance until the item is finished. A clear finishes on
// acceptance; an observe does an extremes RAM read, then a write back. A
// normalize that needs the divider does a RAM read, a range check, 16 steps
// of the shared restoring divider at one quotient bit per cycle, then the
// output load. Normalize shortcuts (unseen column, sample at or below min, at
// or above max, zero range) skip the divider. A result waiting in the output
// register under out_stall holds the block in its final state until taken.
// Extremes sit in one RAM of width 2*SAMPLE_BITS; the per-column seen flags
// are flip-flops, cleared by reset and by a clear item.
module min_max_feature_normalizer_core import mmfn_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [OP_W-1:0]               in_opcode,
  input  logic [COL_W-1:0]              in_column,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [FRAC_BITS-1:0]          out_normalized_value,
  output logic                          out_column_unseen
);

  // only COL_LIMIT columns are addressable through the column field
  localparam int DEPTH = (MAX_COLUMNS < COL_LIMIT) ? MAX_COLUMNS : COL_LIMIT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SB    = SAMPLE_BITS;

  state_t state_r, state_nxt;

  logic                 accept;
  logic                 col_ok;
  logic [AW-1:0]        in_idx;
  logic                 in_seen;
  logic [DEPTH-1:0]     seen_r, seen_nxt;
  logic [AW-1:0]        col_r;
  logic signed [SB-1:0] x_r;

  // extremes RAM
  logic                 ram_we;
  logic [2*SB-1:0]      ram_wdata;
  logic [2*SB-1:0]      ram_rdata;
  logic signed [SB-1:0] lo, hi;
  logic signed [SB-1:0] lo_new, hi_new;

  // range check
  logic signed [SB:0]   num_w, rng_w;
  logic                 num_pos, rng_zero, num_ge, div_go;

  // divider
  logic                 div_start;
  logic [FRAC_BITS-1:0] div_quot;
  div_stat_t            div_stat;

  // result staging and output register
  logic [FRAC_BITS-1:0] res_r;
  logic                 unseen_r;
  logic                 from_div_r;
  logic                 slot_free;
  logic                 out_load;
  logic                 out_valid_r, out_valid_nxt;
  logic [FRAC_BITS-1:0] out_value_r;
  logic                 out_unseen_r;

  assign accept  = in_valid && !in_stall;
  assign col_ok  = (int'(in_column) < MAX_COLUMNS);
  assign in_idx  = in_column[AW-1:0];
  assign in_seen = col_ok && seen_r[in_idx];

  assign slot_free = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // Extremes store: {max, min} per column. Read address follows the input so
  // the entry is ready the cycle after acceptance.
  mmfn_ram #(
    .WIDTH (2 * SB),
    .DEPTH (DEPTH)
  ) u_ext_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_r),
    .wdata (ram_wdata),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  assign lo = $signed(ram_rdata[SB-1:0]);
  assign hi = $signed(ram_rdata[2*SB-1:SB]);

  // observe update; first sample of a column sets both extremes
  always_comb begin
    if (!seen_r[col_r]) begin
      lo_new = x_r;
      hi_new = x_r;
    end else begin
      lo_new = (x_r < lo) ? x_r : lo;
      hi_new = (x_r > hi) ? x_r : hi;
    end
  end

  assign ram_wdata = {hi_new, lo_new};

  // ---------------------------------------------------------------------------
  // Range check: num = x - min, range = max - min, both one bit wider.
  assign num_w    = $signed({x_r[SB-1], x_r}) - $signed({lo[SB-1], lo});
  assign rng_w    = $signed({hi[SB-1], hi}) - $signed({lo[SB-1], lo});
  assign num_pos  = !num_w[SB] && (num_w != '0);
  assign rng_zero = (rng_w == '0);
  assign num_ge   = (num_w >= rng_w);
  assign div_go   = num_pos && !rng_zero && !num_ge;

  mmfn_div #(
    .SAMPLE_BITS (SB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_w[SB-1:0]),
    .den   (rng_w[SB-1:0]),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_OBSERVE: begin
              if (col_ok) begin
                state_nxt = ST_OBS;
              end
            end
            OP_NORMALIZE: begin
              state_nxt = in_seen ? ST_CHECK : ST_DONE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_OBS: begin
        state_nxt = ST_IDLE;
      end
      ST_CHECK: begin
        state_nxt = div_go ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = slot_free ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    ram_we    = (state_r == ST_OBS);
    div_start = (state_r == ST_CHECK) && div_go;
    out_load  = 1'b0;
    case (state_r)
      ST_DIV:  out_load = div_stat.done && slot_free;
      ST_DONE: out_load = slot_free;
      default: out_load = 1'b0;
    endcase
  end

  // seen flags: cleared by a clear item, set on write-back of an observe
  always_comb begin
    seen_nxt = seen_r;
    if (accept && (in_opcode == OP_CLEAR)) begin
      seen_nxt = '0;
    end else if (state_r == ST_OBS) begin
      seen_nxt[col_r] = 1'b1;
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r <= in_idx;
      x_r   <= in_sample_value;
      if (in_opcode == OP_NORMALIZE) begin
        res_r      <= '0;
        unseen_r   <= !in_seen;
        from_div_r <= 1'b0;
      end
    end
    if (state_r == ST_CHECK) begin
      res_r      <= (num_pos && !div_go) ? FRAC_MAX : '0;
      from_div_r <= div_go;
    end
    if (out_load) begin
      out_value_r  <= from_div_r ? div_quot : res_r;
      out_unseen_r <= unseen_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_normalized_value = out_value_r;
  assign out_column_unseen    = out_unseen_r;

`ifndef NO_ASSERTIONS
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == ST_DIV))
    else $error("divider busy outside divide state");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_CLEAR)) |=> (seen_r == '0))
    else $error("clear left a column marked seen");

  a_unseen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_column_unseen) |-> (out_normalized_value == '0))
    else $error("unseen column result not zero");
`endif

endmodule

>>> dv/min_max_feature_normalizer_checker.sv
`timescale 1ns / 100ps
// Checker for the min-max feature normalizer: watches both channels, keeps its own
// column extremes and compares each result with the oldest predicted one.
// Depends on mmfn_pkg.
module min_max_feature_normalizer_checker import mmfn_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [OP_W-1:0]               in_opcode,
  input  logic [COL_W-1:0]              in_column,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [FRAC_BITS-1:0]          out_normalized_value,
  input  logic                          out_column_unseen,
  output int                            error_count,
  output int                            pending_count
);

  typedef struct packed {
    logic [FRAC_BITS-1:0] frac;
    logic                 unseen;
  } norm_result_t;

  norm_result_t                  expected_q[$];
  logic signed [SAMPLE_BITS-1:0] col_min[COL_LIMIT];
  logic signed [SAMPLE_BITS-1:0] col_max[COL_LIMIT];
  logic                          col_seen[COL_LIMIT];
  int                            mismatch_total = 0;
  int                            waiting_total = 0;

  assign error_count   = mismatch_total;
  assign pending_count = waiting_total;

  // (x - lo) / (hi - lo) as Q0.16, truncated, clamped to [0, FRAC_MAX]
  function automatic logic [FRAC_BITS-1:0] scale_to_fraction(
    input logic signed [SAMPLE_BITS-1:0] x,
    input logic signed [SAMPLE_BITS-1:0] lo,
    input logic signed [SAMPLE_BITS-1:0] hi
  );
    longint span;
    longint offset;
    span   = longint'(hi) - longint'(lo);
    offset = longint'(x) - longint'(lo);
    if (span <= 0) span = 1;
    if (offset <= 0) return '0;
    if (offset >= span) return FRAC_MAX;
    return FRAC_BITS'((offset <<< FRAC_BITS) / span);
  endfunction

  always @(posedge clk) begin : watch_channels
    norm_result_t got;
    norm_result_t want;
    if (!rst_n) begin
      foreach (col_seen[i]) col_seen[i] = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{frac: out_normalized_value, unseen: out_column_unseen};
        if (expected_q.size() == 0) begin
          mismatch_total++;
          $display("%0t: result with nothing expected, actual value %0d unseen %0b",
                   $time, got.frac, got.unseen);
        end else begin
          want = expected_q.pop_front();
          if (got.frac != want.frac) begin
            mismatch_total++;
            $display("%0t: normalized_value mismatch, expected %0d actual %0d",
                     $time, want.frac, got.frac);
          end
          if (got.unseen != want.unseen) begin
            mismatch_total++;
            $display("%0t: column_unseen mismatch, expected %0b actual %0b",
                     $time, want.unseen, got.unseen);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_opcode)
          OP_OBSERVE: begin
            if (in_column < MAX_COLUMNS) begin
              if (!col_seen[in_column]) begin
                col_min[in_column]  = in_sample_value;
                col_max[in_column]  = in_sample_value;
                col_seen[in_column] = 1'b1;
              end else begin
                if (in_sample_value > col_max[in_column]) col_max[in_column] = in_sample_value;
                if (in_sample_value < col_min[in_column]) col_min[in_column] = in_sample_value;
              end
            end
          end
          OP_NORMALIZE: begin
            if (in_column >= MAX_COLUMNS || !col_seen[in_column])
              expected_q.push_back('{frac: '0, unseen: 1'b1});
            else
              expected_q.push_back('{frac: scale_to_fraction(in_sample_value,
                                       col_min[in_column], col_max[in_column]),
                                     unseen: 1'b0});
          end
          OP_CLEAR: foreach (col_seen[i]) col_seen[i] = 1'b0;
          default: ;
        endcase
      end
    end
    waiting_total = expected_q.size();
  end

endmodule

>>> dv/min_max_feature_normalizer_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for min_max_feature_normalizer_core: drives directed and random items,
// random stalls on both sides, and reports the verdict.
// Depends on mmfn_pkg, the core RTL and min_max_feature_normalizer_checker.
module min_max_feature_normalizer_core_tb;
  import mmfn_pkg::*;

  localparam int MAX_COLUMNS     = DEF_MAX_COLUMNS;
  localparam int SAMPLE_BITS     = DEF_SAMPLE_BITS;
  localparam int RANDOM_ITEMS    = 930;   // random part length, ignored opcodes excluded
  localparam int HOLD_OFF_CYCLES = 250;   // long receiver hold-off
  localparam int TAIL_CYCLES     = 40;    // exceeds the longest item, with margin
  // No-progress limit: longest item plus longest hold-off, several times over
  localparam int STALL_LIMIT     = 4000;

  // Opcode 3 is not decoded by the block; it must be swallowed silently
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [OP_W-1:0]               in_opcode = OP_OBSERVE;
  logic [COL_W-1:0]              in_column = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [FRAC_BITS-1:0]          out_normalized_value;
  logic                          out_column_unseen;

  int error_count;
  int pending_count;

  // Idle percentages per side, and the hold-off handed to the receiver process
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int items_done = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  min_max_feature_normalizer_core #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_column            (in_column),
    .in_sample_value      (in_sample_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_normalized_value (out_normalized_value),
    .out_column_unseen    (out_column_unseen)
  );

  min_max_feature_normalizer_checker #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_column            (in_column),
    .in_sample_value      (in_sample_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_normalized_value (out_normalized_value),
    .out_column_unseen    (out_column_unseen),
    .error_count          (error_count),
    .pending_count        (pending_count)
  );

  // Receiver: a pending hold-off request wins over the random stall.
  // hold_request is written at rising edges only, so reading it here is race free.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Clamp an int to the signed sample range
  function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return SAMPLE_BITS'(v);
  endfunction

  // Offer one item and wait for it to be taken. Maybe idle first; each
  // falling edge assigns in_valid at most once.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [COL_W-1:0] col,
                           input logic signed [SAMPLE_BITS-1:0] value);
    int gap;
    if ($urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_column       <= col;
    in_sample_value <= value;
    do @(posedge clk); while (in_stall);
    if (op != OP_UNUSED) items_done++;
  endtask

  // Stop offering until the checker holds no outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Well-formed sequence: observe a few samples of one column inside a chosen
  // window, then normalize samples around and inside that window.
  task automatic run_column_burst();
    int col;
    int span;
    int base;
    int n_obs;
    int n_norm;
    col = $urandom_range(0, MAX_COLUMNS - 1);
    case ($urandom_range(0, 3))
      0: span = $urandom_range(0, 8);
      1: span = $urandom_range(9, 1000);
      2: span = $urandom_range(1001, 65535);
      default: span = 0;                      // zero range column
    endcase
    base   = int'($urandom_range(0, 65535 - span)) - 32768;
    n_obs  = $urandom_range(1, 4);
    n_norm = $urandom_range(1, 5);
    // Pin both ends of the window now and then so the full range is known
    if ($urandom_range(1)) begin
      send_item(OP_OBSERVE, col, to_sample(base));
      send_item(OP_OBSERVE, col, to_sample(base + span));
    end
    repeat (n_obs)
      send_item(OP_OBSERVE, col, to_sample(base + int'($urandom_range(0, span))));
    repeat (n_norm)
      send_item(OP_NORMALIZE, col,
                to_sample(base - span / 4 - 2 + int'($urandom_range(0, span + span / 2 + 4))));
  endtask

  // Noise: any opcode, any column, any sample
  task automatic send_noise();
    int pick;
    logic [OP_W-1:0] op;
    pick = $urandom_range(99);
    if (pick < 3)       op = OP_CLEAR;
    else if (pick < 8)  op = OP_UNUSED;
    else if (pick < 50) op = OP_OBSERVE;
    else                op = OP_NORMALIZE;
    send_item(op, COL_W'($urandom_range(0, MAX_COLUMNS - 1)), SAMPLE_BITS'($urandom));
  endtask

  initial begin
    int phase;
    int last_phase;
    int holds_issued;
    holds_issued = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    send_item(OP_NORMALIZE, 6'd5, 16'sd0);          // nothing observed yet
    send_item(OP_UNUSED, 6'd5, 16'sd77);            // undecoded opcode, no effect
    send_item(OP_NORMALIZE, 6'd5, 16'sd77);
    send_item(OP_OBSERVE, 6'd0, 16'sh8000);         // full signed range
    send_item(OP_OBSERVE, 6'd0, 16'sh7fff);
    send_item(OP_NORMALIZE, 6'd0, 16'sh8000);       // at minimum
    send_item(OP_NORMALIZE, 6'd0, 16'sh7fff);       // at maximum
    send_item(OP_NORMALIZE, 6'd0, 16'sd0);
    send_item(OP_NORMALIZE, 6'd0, -16'sd1);
    send_item(OP_OBSERVE, 6'd63, 16'sd100);         // zero range
    send_item(OP_NORMALIZE, 6'd63, 16'sd100);
    send_item(OP_NORMALIZE, 6'd63, 16'sd101);
    send_item(OP_NORMALIZE, 6'd63, 16'sd99);
    send_item(OP_OBSERVE, 6'd1, 16'sd20);           // max first, min lowered later
    send_item(OP_OBSERVE, 6'd1, 16'sd10);
    send_item(OP_NORMALIZE, 6'd1, 16'sd15);
    send_item(OP_NORMALIZE, 6'd1, 16'sd5);          // below minimum
    send_item(OP_NORMALIZE, 6'd1, 16'sd25);         // above maximum
    send_item(OP_NORMALIZE, 6'd1, 16'sd19);
    send_item(OP_CLEAR, 6'd0, 16'sd0);
    send_item(OP_NORMALIZE, 6'd0, 16'sd0);          // forgotten after clear
    send_item(OP_OBSERVE, 6'd0, 16'sh5555);         // first sample after clear
    send_item(OP_NORMALIZE, 6'd0, 16'shaaaa);
    send_item(OP_NORMALIZE, 6'd63, 16'sd100);
    send_item(OP_UNUSED, 6'd42, 16'sh1234);
    drain_results();

    // Random part in three idle profiles
    items_done = 0;
    last_phase = -1;
    while (items_done < RANDOM_ITEMS) begin
      phase = items_done * 3 / RANDOM_ITEMS;
      if (phase != last_phase) begin
        case (phase)
          0: begin
            src_idle_pct   = 37;
            sink_stall_pct = 58;
          end
          1: begin
            // Sender waits out every result before the profile flips
            drain_results();
            src_idle_pct   = 58;
            sink_stall_pct = 37;
          end
          default: begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
          end
        endcase
        last_phase = phase;
      end
      // Long receiver hold-off while items keep coming, once in each of the
      // first two profiles; the block must fill up and hold in_stall
      if ((holds_issued == 0 && items_done >= 60) ||
          (holds_issued == 1 && items_done >= RANDOM_ITEMS / 3 + 60)) begin
        hold_request = HOLD_OFF_CYCLES;
        holds_issued++;
      end
      if ($urandom_range(99) < 80) run_column_burst();
      else send_noise();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mmfn_pkg.sv
rtl/mmfn_ram.sv
rtl/mmfn_div.sv
rtl/min_max_feature_normalizer_core.sv
dv/min_max_feature_normalizer_checker.sv
dv/min_max_feature_normalizer_core_tb.sv
